### hdl/lc3_pkg.sv
// ----------------------------------------------------------------------------
// lc3_pkg
// shared types, codes and helpers for the lc3 instruction step core
// ----------------------------------------------------------------------------
package lc3_pkg;

  localparam int ADDR_BITS_DEF = 16;
  localparam int WORD_W        = 16;
  localparam int KIND_W        = 3;
  localparam int RIDX_W        = 3;
  localparam int CC_W          = 3;
  localparam int IN_TDATA_W    = 40;
  localparam int OUT_TDATA_W   = 40;

  localparam logic [KIND_W-1:0] KIND_MEM_WR = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MEM_RD = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REG_WR = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REG_RD = 3'd3;
  localparam logic [KIND_W-1:0] KIND_START  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_STEP   = 3'd5;

  localparam logic [3:0] OP_BR   = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_LD   = 4'd2;
  localparam logic [3:0] OP_ST   = 4'd3;
  localparam logic [3:0] OP_JSR  = 4'd4;
  localparam logic [3:0] OP_AND  = 4'd5;
  localparam logic [3:0] OP_LDR  = 4'd6;
  localparam logic [3:0] OP_STR  = 4'd7;
  localparam logic [3:0] OP_RTI  = 4'd8;
  localparam logic [3:0] OP_NOT  = 4'd9;
  localparam logic [3:0] OP_LDI  = 4'd10;
  localparam logic [3:0] OP_STI  = 4'd11;
  localparam logic [3:0] OP_JMP  = 4'd12;
  localparam logic [3:0] OP_RES  = 4'd13;
  localparam logic [3:0] OP_LEA  = 4'd14;
  localparam logic [3:0] OP_TRAP = 4'd15;

  localparam logic [7:0]      TRAP_HALT = 8'h25;
  localparam logic [RIDX_W-1:0] LINK_REG = 3'd7;

  localparam logic [CC_W-1:0] CC_NONE = 3'd0;
  localparam logic [CC_W-1:0] CC_P    = 3'd1;
  localparam logic [CC_W-1:0] CC_Z    = 3'd2;
  localparam logic [CC_W-1:0] CC_N    = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MEM_WR, ST_MEM_RD, ST_MEM_CAP, ST_SIMPLE, ST_FETCH,
    ST_DECODE, ST_EXEC, ST_IND, ST_LOAD, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    CMD_IDLE, CMD_MEM_WR, CMD_MEM_RD, CMD_MEM_CAP, CMD_SIMPLE, CMD_FETCH,
    CMD_DECODE, CMD_EXEC, CMD_IND, CMD_LOAD, CMD_DONE
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic load_out;
  } ctl_t;

  typedef struct packed {
    logic [3:0] ir_op;
    logic       out_free;
  } stat_t;

  function automatic logic [WORD_W-1:0] sext5(input logic [4:0] v);
    return {{11{v[4]}}, v};
  endfunction

  function automatic logic [WORD_W-1:0] sext6(input logic [5:0] v);
    return {{10{v[5]}}, v};
  endfunction

  function automatic logic [WORD_W-1:0] sext9(input logic [8:0] v);
    return {{7{v[8]}}, v};
  endfunction

  function automatic logic [WORD_W-1:0] sext11(input logic [10:0] v);
    return {{5{v[10]}}, v};
  endfunction

  function automatic logic [CC_W-1:0] cc_of(input logic [WORD_W-1:0] v);
    logic [CC_W-1:0] c;
    if (v[WORD_W-1]) c = CC_N;
    else if (v == '0) c = CC_Z;
    else c = CC_P;
    return c;
  endfunction

endpackage

### hdl/lc3_instruction_step_core.sv
// ----------------------------------------------------------------------------
// lc3_instruction_step_core
// 16-bit lc3 style core stepping one command or instruction per input beat
// ----------------------------------------------------------------------------
// one item at a time: a new beat is taken only when idle, after the last
// result has gone into the output stage; steps run fetch, decode, execute
// and, for loads and indirect access, further states on the single memory
// port; the output stage holds its result while out_tready is low
// synchronous reset clears gprs, pc, flags and the output valid bit;
// the word memory is not cleared
module lc3_instruction_step_core #(
  parameter int ADDR_BITS = lc3_pkg::ADDR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lc3_pkg::IN_TDATA_W-1:0]  in_tdata,   // address, data, reg_index
  input  logic [lc3_pkg::KIND_W-1:0]      in_tuser,   // kind
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lc3_pkg::OUT_TDATA_W-1:0] out_tdata   // read_value, next_pc, cond_flags, halted
);

  lc3_pkg::ctl_t  ctl;
  lc3_pkg::stat_t stat;

  lc3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .ctl       (ctl)
  );

  lc3_dpath #(
    .ADDR_BITS (ADDR_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .stat       (stat),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### hdl/lc3_ctrl.sv
// ----------------------------------------------------------------------------
// lc3_ctrl
// sequencer walking steps through fetch, decode, execute and memory states
// ----------------------------------------------------------------------------
module lc3_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic [lc3_pkg::KIND_W-1:0] in_kind,
  output logic                      in_tready,
  input  lc3_pkg::stat_t            stat,
  output lc3_pkg::ctl_t             ctl
);

  lc3_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lc3_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lc3_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          priority case (in_kind)
            lc3_pkg::KIND_MEM_WR: state_nxt = lc3_pkg::ST_MEM_WR;
            lc3_pkg::KIND_MEM_RD: state_nxt = lc3_pkg::ST_MEM_RD;
            lc3_pkg::KIND_STEP:   state_nxt = lc3_pkg::ST_FETCH;
            default:              state_nxt = lc3_pkg::ST_SIMPLE;
          endcase
        end
      end
      lc3_pkg::ST_MEM_WR:  state_nxt = lc3_pkg::ST_DONE;
      lc3_pkg::ST_MEM_RD:  state_nxt = lc3_pkg::ST_MEM_CAP;
      lc3_pkg::ST_MEM_CAP: state_nxt = lc3_pkg::ST_DONE;
      lc3_pkg::ST_SIMPLE:  state_nxt = lc3_pkg::ST_DONE;
      lc3_pkg::ST_FETCH:   state_nxt = lc3_pkg::ST_DECODE;
      lc3_pkg::ST_DECODE:  state_nxt = lc3_pkg::ST_EXEC;
      lc3_pkg::ST_EXEC: begin
        if (stat.ir_op == lc3_pkg::OP_LD || stat.ir_op == lc3_pkg::OP_LDR) begin
          state_nxt = lc3_pkg::ST_LOAD;
        end else if (stat.ir_op == lc3_pkg::OP_LDI || stat.ir_op == lc3_pkg::OP_STI) begin
          state_nxt = lc3_pkg::ST_IND;
        end else begin
          state_nxt = lc3_pkg::ST_DONE;
        end
      end
      lc3_pkg::ST_IND: begin
        state_nxt = (stat.ir_op == lc3_pkg::OP_LDI) ? lc3_pkg::ST_LOAD : lc3_pkg::ST_DONE;
      end
      lc3_pkg::ST_LOAD: state_nxt = lc3_pkg::ST_DONE;
      lc3_pkg::ST_DONE: begin
        if (stat.out_free) state_nxt = lc3_pkg::ST_IDLE;
      end
      default: state_nxt = lc3_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready    = 1'b0;
    ctl.load_out = 1'b0;
    ctl.cmd      = lc3_pkg::CMD_IDLE;
    unique case (state_r)
      lc3_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        ctl.cmd   = lc3_pkg::CMD_IDLE;
      end
      lc3_pkg::ST_MEM_WR:  ctl.cmd = lc3_pkg::CMD_MEM_WR;
      lc3_pkg::ST_MEM_RD:  ctl.cmd = lc3_pkg::CMD_MEM_RD;
      lc3_pkg::ST_MEM_CAP: ctl.cmd = lc3_pkg::CMD_MEM_CAP;
      lc3_pkg::ST_SIMPLE:  ctl.cmd = lc3_pkg::CMD_SIMPLE;
      lc3_pkg::ST_FETCH:   ctl.cmd = lc3_pkg::CMD_FETCH;
      lc3_pkg::ST_DECODE:  ctl.cmd = lc3_pkg::CMD_DECODE;
      lc3_pkg::ST_EXEC:    ctl.cmd = lc3_pkg::CMD_EXEC;
      lc3_pkg::ST_IND:     ctl.cmd = lc3_pkg::CMD_IND;
      lc3_pkg::ST_LOAD:    ctl.cmd = lc3_pkg::CMD_LOAD;
      lc3_pkg::ST_DONE: begin
        ctl.cmd      = lc3_pkg::CMD_DONE;
        ctl.load_out = stat.out_free;
      end
      default: ctl.cmd = lc3_pkg::CMD_IDLE;
    endcase
  end

endmodule

### hdl/lc3_dpath.sv
// ----------------------------------------------------------------------------
// lc3_dpath
// word memory, register file, pc, condition bits and the result register
// ----------------------------------------------------------------------------
module lc3_dpath #(
  parameter int ADDR_BITS = lc3_pkg::ADDR_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lc3_pkg::ctl_t                  ctl,
  output lc3_pkg::stat_t                 stat,
  input  logic                           in_tvalid,
  input  logic [lc3_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [lc3_pkg::KIND_W-1:0]     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [lc3_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int W = lc3_pkg::WORD_W;

  logic [W-1:0] word_mem [2**ADDR_BITS];

  logic [lc3_pkg::KIND_W-1:0] kind_r;
  logic [W-1:0]               addr_r, data_r;
  logic [lc3_pkg::RIDX_W-1:0] ri_r;
  logic [W-1:0]               gpr_r [8];
  logic [W-1:0]               pc_r, pc_nxt;
  logic [lc3_pkg::CC_W-1:0]   cc_r, cc_nxt;
  logic [W-1:0]               ir_r, ra_r, rb_r, mem_q_r;
  logic [W-1:0]               rv_r, rv_nxt;
  logic                       halt_r, halt_nxt;
  logic [lc3_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic                       out_valid_r;

  logic [lc3_pkg::RIDX_W-1:0] ra_addr, rb_addr, gpr_wa;
  logic                       gpr_we, mem_we, mem_re;
  logic [W-1:0]               gpr_wd, mem_addr, mem_wd;
  logic [3:0]                 dec_op, op;
  logic [lc3_pkg::RIDX_W-1:0] r9;
  logic [W-1:0]               b_val, off9, base6, alu_add, alu_and, alu_not;

  // register file read ports, registered
  assign dec_op  = mem_q_r[15:12];
  assign ra_addr = (ctl.cmd != lc3_pkg::CMD_DECODE) ? in_tdata[34:32] :
                   (dec_op == lc3_pkg::OP_RTI || dec_op == lc3_pkg::OP_RES) ?
                   lc3_pkg::LINK_REG : mem_q_r[8:6];
  assign rb_addr = (dec_op == lc3_pkg::OP_ADD || dec_op == lc3_pkg::OP_AND) ?
                   mem_q_r[2:0] : mem_q_r[11:9];

  assign op      = ir_r[15:12];
  assign r9      = ir_r[11:9];
  assign b_val   = ir_r[5] ? lc3_pkg::sext5(ir_r[4:0]) : rb_r;
  assign off9    = pc_r + lc3_pkg::sext9(ir_r[8:0]);
  assign base6   = ra_r + lc3_pkg::sext6(ir_r[5:0]);
  assign alu_add = ra_r + b_val;
  assign alu_and = ra_r & b_val;
  assign alu_not = ~ra_r;

  always_comb begin
    pc_nxt   = pc_r;
    cc_nxt   = cc_r;
    gpr_we   = 1'b0;
    gpr_wa   = r9;
    gpr_wd   = mem_q_r;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = pc_r;
    mem_wd   = rb_r;
    rv_nxt   = rv_r;
    halt_nxt = halt_r;
    unique case (ctl.cmd)
      lc3_pkg::CMD_IDLE: begin
        if (in_tvalid) begin
          rv_nxt   = '0;
          halt_nxt = 1'b0;
        end
      end
      lc3_pkg::CMD_MEM_WR: begin
        mem_we   = 1'b1;
        mem_addr = addr_r;
        mem_wd   = data_r;
      end
      lc3_pkg::CMD_MEM_RD: begin
        mem_re   = 1'b1;
        mem_addr = addr_r;
      end
      lc3_pkg::CMD_MEM_CAP: rv_nxt = mem_q_r;
      lc3_pkg::CMD_SIMPLE: begin
        priority case (kind_r)
          lc3_pkg::KIND_REG_WR: begin
            gpr_we = 1'b1;
            gpr_wa = ri_r;
            gpr_wd = data_r;
          end
          lc3_pkg::KIND_REG_RD: rv_nxt = ra_r;
          lc3_pkg::KIND_START: begin
            pc_nxt = addr_r;
            cc_nxt = lc3_pkg::CC_NONE;
          end
          default: ;
        endcase
      end
      lc3_pkg::CMD_FETCH: begin
        mem_re   = 1'b1;
        mem_addr = pc_r;
        pc_nxt   = pc_r + W'(1);
      end
      lc3_pkg::CMD_DECODE: begin
        rv_nxt   = mem_q_r;
        halt_nxt = (mem_q_r == '0);
      end
      lc3_pkg::CMD_EXEC: begin
        unique case (op)
          lc3_pkg::OP_BR: begin
            if ((r9 & cc_r) != '0) pc_nxt = off9;
          end
          lc3_pkg::OP_ADD: begin
            gpr_we = 1'b1;
            gpr_wd = alu_add;
            cc_nxt = lc3_pkg::cc_of(alu_add);
          end
          lc3_pkg::OP_AND: begin
            gpr_we = 1'b1;
            gpr_wd = alu_and;
            cc_nxt = lc3_pkg::cc_of(alu_and);
          end
          lc3_pkg::OP_NOT: begin
            gpr_we = 1'b1;
            gpr_wd = alu_not;
            cc_nxt = lc3_pkg::cc_of(alu_not);
          end
          lc3_pkg::OP_LD, lc3_pkg::OP_LDI, lc3_pkg::OP_STI: begin
            mem_re   = 1'b1;
            mem_addr = off9;
          end
          lc3_pkg::OP_ST: begin
            mem_we   = 1'b1;
            mem_addr = off9;
          end
          lc3_pkg::OP_LDR: begin
            mem_re   = 1'b1;
            mem_addr = base6;
          end
          lc3_pkg::OP_STR: begin
            mem_we   = 1'b1;
            mem_addr = base6;
          end
          lc3_pkg::OP_JSR: begin
            gpr_we = 1'b1;
            gpr_wa = lc3_pkg::LINK_REG;
            gpr_wd = pc_r;
            pc_nxt = ir_r[11] ? pc_r + lc3_pkg::sext11(ir_r[10:0]) : ra_r;
          end
          lc3_pkg::OP_JMP, lc3_pkg::OP_RTI, lc3_pkg::OP_RES: pc_nxt = ra_r;
          lc3_pkg::OP_LEA: begin
            gpr_we = 1'b1;
            gpr_wd = off9;
          end
          lc3_pkg::OP_TRAP: begin
            if (ir_r[7:0] == lc3_pkg::TRAP_HALT) pc_nxt = '0;
          end
          default: ;
        endcase
      end
      lc3_pkg::CMD_IND: begin
        mem_addr = mem_q_r;
        if (op == lc3_pkg::OP_LDI) begin
          mem_re = 1'b1;
        end else begin
          mem_we = 1'b1;
        end
      end
      lc3_pkg::CMD_LOAD: begin
        gpr_we = 1'b1;
        gpr_wd = mem_q_r;
        cc_nxt = lc3_pkg::cc_of(mem_q_r);
      end
      lc3_pkg::CMD_DONE: ;
      default: ;
    endcase
  end

  // word memory, one port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      word_mem[mem_addr[ADDR_BITS-1:0]] <= mem_wd;
    end
    if (mem_re) begin
      mem_q_r <= word_mem[mem_addr[ADDR_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmd == lc3_pkg::CMD_IDLE && in_tvalid) begin
      kind_r <= in_tuser;
      addr_r <= in_tdata[15:0];
      data_r <= in_tdata[31:16];
      ri_r   <= in_tdata[34:32];
    end
    if (ctl.cmd == lc3_pkg::CMD_IDLE || ctl.cmd == lc3_pkg::CMD_DECODE) begin
      ra_r <= gpr_r[ra_addr];
    end
    if (ctl.cmd == lc3_pkg::CMD_DECODE) begin
      rb_r <= gpr_r[rb_addr];
      ir_r <= mem_q_r;
    end
    rv_r   <= rv_nxt;
    halt_r <= halt_nxt;
    if (ctl.load_out) begin
      out_data_r <= {4'b0000, halt_r, cc_r, pc_r, rv_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        gpr_r[i] <= '0;
      end
      pc_r        <= '0;
      cc_r        <= lc3_pkg::CC_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (gpr_we) begin
        gpr_r[gpr_wa] <= gpr_wd;
      end
      pc_r <= pc_nxt;
      cc_r <= cc_nxt;
      if (ctl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.ir_op    = op;
  assign stat.out_free = !out_valid_r || out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;

endmodule

### hdl/lc3_chk.sv
// ----------------------------------------------------------------------------
// lc3_chk
// port-level checks for the lc3 instruction step core
// ----------------------------------------------------------------------------
module lc3_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [lc3_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic [lc3_pkg::KIND_W-1:0]      in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [lc3_pkg::OUT_TDATA_W-1:0] out_tdata
);

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while busy");

  a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == lc3_pkg::KIND_START && !out_tvalid) |->
    ##3 (out_tvalid && out_tdata[31:16] == $past(in_tdata[15:0], 3) &&
         out_tdata[34:32] == lc3_pkg::CC_NONE))
    else $error("start result wrong");

  a_halt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[35]) |-> (out_tdata[15:0] == '0))
    else $error("halt with nonzero word");

  a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0(out_tdata[34:32]))
    else $error("condition flags not one-hot");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result dropped or changed");

endmodule

bind lc3_instruction_step_core lc3_chk u_lc3_chk (.*);

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for lc3_instruction_step_core: a short table of
// directed beats covers reset values, address and data extremes, pc wrap,
// every command kind and the odd instruction cases. A long random part then
// runs short programs with random content and random command beats. Each
// result is compared field by field with fixed table values or an in-bench
// model. Both streams idle at random. Memory is written before it is read.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lc3_pkg::*;

  localparam int ITEM_TARGET = 1400;
  localparam int CALM_TAIL   = 200;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_WAIT  = 16;
  localparam logic [KIND_W-1:0] KIND_UNUSED6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_UNUSED7 = 3'd7;
  localparam logic [WORD_W-1:0] AMASK =
    16'((32'd1 << ADDR_BITS_DEF) - 32'd1);

  // low bits first: rv, pc, cc, halted
  typedef struct packed {
    logic              halted;
    logic [CC_W-1:0]   cc;
    logic [WORD_W-1:0] pc;
    logic [WORD_W-1:0] rv;
  } lc3_result_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] addr;
    logic [WORD_W-1:0] data;
    logic [RIDX_W-1:0] ridx;
    logic              fixed;
    logic [WORD_W-1:0] rv;
    logic [WORD_W-1:0] pc;
    logic [CC_W-1:0]   cc;
    logic              halt;
  } dir_row_t;

  // kind, addr, data, ridx, fixed, rv, pc, cc, halt
  localparam dir_row_t DIR_ROWS [26] = '{
    '{KIND_REG_RD,  16'h0000, 16'h0000, 3'd3, 1'b1, 16'h0000, 16'h0000, CC_NONE, 1'b0},
    '{KIND_UNUSED6, 16'hFFFF, 16'hFFFF, 3'd7, 1'b1, 16'h0000, 16'h0000, CC_NONE, 1'b0},
    '{KIND_MEM_WR,  16'hFFFF, 16'h0000, 3'd0, 1'b1, 16'h0000, 16'h0000, CC_NONE, 1'b0},
    '{KIND_START,   16'hFFFF, 16'h0000, 3'd0, 1'b1, 16'h0000, 16'hFFFF, CC_NONE, 1'b0},
    '{KIND_STEP,    16'h0000, 16'h0000, 3'd0, 1'b1, 16'h0000, 16'h0000, CC_NONE, 1'b1},
    '{KIND_REG_WR,  16'h0000, 16'hFFFF, 3'd7, 1'b1, 16'h0000, 16'h0000, CC_NONE, 1'b0},
    '{KIND_REG_RD,  16'h0000, 16'h0000, 3'd7, 1'b1, 16'hFFFF, 16'h0000, CC_NONE, 1'b0},
    '{KIND_MEM_WR,  16'h0000, {OP_JSR, 3'b000, LINK_REG, 6'h00}, 3'd0, 1'b0,
      16'h0, 16'h0, CC_NONE, 1'b0},
    '{KIND_STEP,    16'h0000, 16'h0000, 3'd0, 1'b0, 16'h0, 16'h0, CC_NONE, 1'b0},
    '{KIND_MEM_WR,  16'hFFFF, {OP_NOT, 3'd0, LINK_REG, 6'h3F}, 3'd0, 1'b0,
      16'h0, 16'h0, CC_NONE, 1'b0},
    '{KIND_STEP,    16'h0000, 16'h0000, 3'd0, 1'b0, 16'h0, 16'h0, CC_NONE, 1'b0},
    '{KIND_MEM_WR,  16'h0000, {OP_LEA, 3'd2, 9'h1FF}, 3'd0, 1'b0,
      16'h0, 16'h0, CC_NONE, 1'b0},
    '{KIND_STEP,    16'h0000, 16'h0000, 3'd0, 1'b0, 16'h0, 16'h0, CC_NONE, 1'b0},
    '{KIND_MEM_WR,  16'h0001, {OP_TRAP, 4'h0, TRAP_HALT}, 3'd0, 1'b0,
      16'h0, 16'h0, CC_NONE, 1'b0},
    '{KIND_STEP,    16'h0000, 16'h0000, 3'd0, 1'b0, 16'h0, 16'h0, CC_NONE, 1'b0},
    '{KIND_MEM_WR,  16'h0000, {OP_RTI, 12'h000}, 3'd0, 1'b0,
      16'h0, 16'h0, CC_NONE, 1'b0},
    '{KIND_STEP,    16'h0000, 16'h0000, 3'd0, 1'b0, 16'h0, 16'h0, CC_NONE, 1'b0},
    '{KIND_MEM_WR,  16'h0001, {OP_TRAP, 4'h0, 8'h23}, 3'd0, 1'b0,
      16'h0, 16'h0, CC_NONE, 1'b0},
    '{KIND_STEP,    16'h0000, 16'h0000, 3'd0, 1'b0, 16'h0, 16'h0, CC_NONE, 1'b0},
    '{KIND_MEM_WR,  16'h0002, {OP_RES, 12'h000}, 3'd0, 1'b0,
      16'h0, 16'h0, CC_NONE, 1'b0},
    '{KIND_STEP,    16'h0000, 16'h0000, 3'd0, 1'b0, 16'h0, 16'h0, CC_NONE, 1'b0},
    '{KIND_UNUSED7, 16'h5A5A, 16'hA5A5, 3'd5, 1'b0, 16'h0, 16'h0, CC_NONE, 1'b0},
    '{KIND_MEM_RD,  16'hFFFF, 16'h0000, 3'd0, 1'b0, 16'h0, 16'h0, CC_NONE, 1'b0},
    '{KIND_START,   16'h0000, 16'h0000, 3'd0, 1'b1, 16'h0000, 16'h0000, CC_NONE, 1'b0},
    '{KIND_REG_WR,  16'h0000, 16'h8000, 3'd0, 1'b1, 16'h0000, 16'h0000, CC_NONE, 1'b0},
    '{KIND_REG_RD,  16'h0000, 16'h0000, 3'd0, 1'b1, 16'h8000, 16'h0000, CC_NONE, 1'b0}
  };

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [KIND_W-1:0]      in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // core image kept by the bench
  logic [WORD_W-1:0] mem_img [logic [WORD_W-1:0]];
  logic [WORD_W-1:0] mem_used [$];
  logic [WORD_W-1:0] gpr [8] = '{default: '0};
  logic [WORD_W-1:0] pc_q = '0;
  logic [CC_W-1:0]   cc_q = CC_NONE;

  lc3_result_t want_q [$];
  lc3_result_t got_r;
  lc3_result_t want_r;
  int          n_fail     = 0;
  int          beats_sent = 0;
  int          cycles     = 0;
  int          stall_left = 0;
  bit          calm       = 1'b0;

  lc3_instruction_step_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [WORD_W-1:0] mem_get(logic [WORD_W-1:0] a);
    return mem_img.exists(a & AMASK) ? mem_img[a & AMASK] : '0;
  endfunction

  function automatic void mem_put(logic [WORD_W-1:0] a, logic [WORD_W-1:0] v);
    if (!mem_img.exists(a & AMASK)) mem_used.push_back(a & AMASK);
    mem_img[a & AMASK] = v;
  endfunction

  function automatic void put_dr(logic [RIDX_W-1:0] dr, logic [WORD_W-1:0] v);
    gpr[dr] = v;
    cc_q = v[WORD_W-1] ? CC_N : (v == '0 ? CC_Z : CC_P);
  endfunction

  function automatic void exec_instr(logic [WORD_W-1:0] ins);
    logic [RIDX_W-1:0] r9;
    logic [RIDX_W-1:0] r6;
    logic [WORD_W-1:0] pc0;
    logic [WORD_W-1:0] off9;
    logic [WORD_W-1:0] off6;
    logic [WORD_W-1:0] opb;
    logic [WORD_W-1:0] ptr;
    logic [WORD_W-1:0] tgt;
    r9   = ins[11:9];
    r6   = ins[8:6];
    pc0  = pc_q;
    off9 = pc0 + {{7{ins[8]}}, ins[8:0]};
    off6 = gpr[r6] + {{10{ins[5]}}, ins[5:0]};
    opb  = ins[5] ? {{11{ins[4]}}, ins[4:0]} : gpr[ins[2:0]];
    case (ins[15:12])
      OP_BR:   if ((r9 & cc_q) != '0) pc_q = off9;
      OP_ADD:  put_dr(r9, gpr[r6] + opb);
      OP_LD:   put_dr(r9, mem_get(off9));
      OP_ST:   mem_put(off9, gpr[r9]);
      OP_JSR: begin
        // base register read before the link write
        tgt = ins[11] ? pc0 + {{5{ins[10]}}, ins[10:0]} : gpr[r6];
        gpr[LINK_REG] = pc0;
        pc_q = tgt;
      end
      OP_AND:  put_dr(r9, gpr[r6] & opb);
      OP_LDR:  put_dr(r9, mem_get(off6));
      OP_STR:  mem_put(off6, gpr[r9]);
      OP_NOT:  put_dr(r9, ~gpr[r6]);
      OP_LDI: begin
        ptr = mem_get(off9);
        put_dr(r9, mem_get(ptr));
      end
      OP_STI: begin
        ptr = mem_get(off9);
        mem_put(ptr, gpr[r9]);
      end
      OP_JMP:  pc_q = gpr[r6];
      OP_LEA:  gpr[r9] = off9;
      OP_TRAP: if (ins[7:0] == TRAP_HALT) pc_q = '0;
      default: pc_q = gpr[LINK_REG];
    endcase
  endfunction

  function automatic lc3_result_t lc3_apply(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] addr,
                                            logic [WORD_W-1:0] data, logic [RIDX_W-1:0] ridx);
    lc3_result_t r = '0;
    case (kind)
      KIND_MEM_WR: mem_put(addr, data);
      KIND_MEM_RD: r.rv = mem_get(addr);
      KIND_REG_WR: gpr[ridx] = data;
      KIND_REG_RD: r.rv = gpr[ridx];
      KIND_START: begin
        pc_q = addr;
        cc_q = CC_NONE;
      end
      KIND_STEP: begin
        r.rv = mem_get(pc_q);
        pc_q = pc_q + 16'd1;
        exec_instr(r.rv);
        r.halted = (r.rv == '0);
      end
      default: ;
    endcase
    r.pc = pc_q;
    r.cc = cc_q;
    return r;
  endfunction

  task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] addr,
                           input logic [WORD_W-1:0] data, input logic [RIDX_W-1:0] ridx,
                           input bit fixed = 1'b0, input lc3_result_t fixed_want = '0);
    lc3_result_t pred;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {5'b0, ridx, data, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = lc3_apply(kind, addr, data, ridx);
    want_q.push_back(fixed ? fixed_want : pred);
    if (kind != KIND_UNUSED6 && kind != KIND_UNUSED7) beats_sent++;
  endtask

  // write a word first where a read would hit an unwritten location
  task automatic ensure_word(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] v);
    if (!mem_img.exists(a & AMASK))
      send_beat(KIND_MEM_WR, a, v, 3'($urandom_range(0, 7)));
  endtask

  initial begin
    lc3_result_t       want;
    logic [WORD_W-1:0] ins;
    logic [WORD_W-1:0] off9;
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] addr;
    int                sel;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < $size(DIR_ROWS); i++) begin
      want.rv     = DIR_ROWS[i].rv;
      want.pc     = DIR_ROWS[i].pc;
      want.cc     = DIR_ROWS[i].cc;
      want.halted = DIR_ROWS[i].halt;
      send_beat(DIR_ROWS[i].kind, DIR_ROWS[i].addr, DIR_ROWS[i].data, DIR_ROWS[i].ridx,
                DIR_ROWS[i].fixed, want);
    end

    // hold off until the core has answered everything
    in_tvalid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);

    while (beats_sent < ITEM_TARGET) begin
      if (beats_sent >= ITEM_TARGET - CALM_TAIL) calm = 1'b1;
      if ($urandom_range(0, 9) < 7) begin
        repeat ($urandom_range(0, 3))
          send_beat(KIND_REG_WR, 16'($urandom),
                    $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 63)),
                    3'($urandom_range(0, 7)));
        if ($urandom_range(0, 3) != 0)
          send_beat(KIND_START, 16'($urandom), 16'($urandom), 3'($urandom_range(0, 7)));
        repeat ($urandom_range(4, 24)) begin
          sel = $urandom_range(0, 99);
          if (sel < 3) ins = '0;
          else if (sel < 8) ins = {OP_TRAP, 4'h0, TRAP_HALT};
          else ins = 16'($urandom);
          ensure_word(pc_q, ins);
          ins  = mem_get(pc_q);
          off9 = pc_q + 16'd1 + {{7{ins[8]}}, ins[8:0]};
          case (ins[15:12])
            OP_LD, OP_LDI, OP_STI: ensure_word(off9, 16'($urandom));
            OP_LDR: ensure_word(gpr[ins[8:6]] + {{10{ins[5]}}, ins[5:0]}, 16'($urandom));
            default: ;
          endcase
          if (ins[15:12] == OP_LDI) ensure_word(mem_get(off9), 16'($urandom));
          send_beat(KIND_STEP, 16'($urandom), 16'($urandom), 3'($urandom_range(0, 7)));
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          kind = 3'($urandom_range(0, 7));
          // steps only run where fetch and operands are prepared
          if (kind == KIND_STEP) kind = KIND_REG_RD;
          addr = 16'($urandom);
          if (kind == KIND_MEM_RD) addr = mem_used[$urandom_range(0, mem_used.size() - 1)];
          send_beat(kind, addr, 16'($urandom), 3'($urandom_range(0, 7)));
        end
      end
    end

    in_tvalid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (n_fail == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_r = out_tdata[35:0];
      if (want_q.size() == 0) begin
        $error("result beat with nothing expected: %h", out_tdata);
        n_fail++;
      end else begin
        want_r = want_q.pop_front();
        if (got_r.rv !== want_r.rv) begin
          $error("read_value: expected %h, got %h", want_r.rv, got_r.rv);
          n_fail++;
        end
        if (got_r.pc !== want_r.pc) begin
          $error("next_pc: expected %h, got %h", want_r.pc, got_r.pc);
          n_fail++;
        end
        if (got_r.cc !== want_r.cc) begin
          $error("cond_flags: expected %h, got %h", want_r.cc, got_r.cc);
          n_fail++;
        end
        if (got_r.halted !== want_r.halted) begin
          $error("halted: expected %b, got %b", want_r.halted, got_r.halted);
          n_fail++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) out_tready <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $error("no end after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
